>>> hdl/assert_macros.svh
// Assertion macros used by the checker file qau_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

// Antecedent implies consequent (a sequence may follow ##n).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

`endif

>>> hdl/qau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Types and constants of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    localparam int PW  = 2 * DATA_WIDTH;
    localparam int AW  = 2 * DATA_WIDTH + 4;
    localparam int SW  = 2 * DATA_WIDTH + 1;
    localparam int MW  = DATA_WIDTH + 1;
    localparam int SQW = 2 * MW;
    localparam int RW  = MW + 3;
    localparam int QW  = FRAC_BITS + 1;
    localparam int DRW = MW + 2;
    localparam int NW  = DATA_WIDTH + FRAC_BITS + 2;
    localparam int LATENCY = MW + QW + 3;

    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_NORM = 2'd1,
        CMD_MAT  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [DATA_WIDTH-1:0] a_w;
        logic signed [DATA_WIDTH-1:0] a_x;
        logic signed [DATA_WIDTH-1:0] a_y;
        logic signed [DATA_WIDTH-1:0] a_z;
        logic signed [DATA_WIDTH-1:0] b_w;
        logic signed [DATA_WIDTH-1:0] b_x;
        logic signed [DATA_WIDTH-1:0] b_y;
        logic signed [DATA_WIDTH-1:0] b_z;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_0;
        logic signed [DATA_WIDTH-1:0] res_1;
        logic signed [DATA_WIDTH-1:0] res_2;
        logic signed [DATA_WIDTH-1:0] res_3;
        logic signed [DATA_WIDTH-1:0] res_4;
        logic signed [DATA_WIDTH-1:0] res_5;
        logic signed [DATA_WIDTH-1:0] res_6;
        logic signed [DATA_WIDTH-1:0] res_7;
        logic signed [DATA_WIDTH-1:0] res_8;
        logic                         overflow;
        logic                         zero_magnitude;
    } out_t;

    // word handed from cell to cell
    typedef struct packed {
        logic                           valid;
        cmd_t                           cmd;
        logic [8:0][DATA_WIDTH-1:0]     res;
        logic                           ov;
        logic                           zm;
        logic [3:0][DATA_WIDTH-1:0]     mag_abs;
        logic [3:0]                     neg;
        logic [SQW-1:0]                 s;
        logic [RW-1:0]                  rem;
        logic [MW-1:0]                  root;
        logic [3:0][DRW-1:0]            drem;
        logic [3:0][QW-1:0]             quo;
        logic [3:0][QW-1:0]             nbits;
        logic [MW:0]                    dvsr;
    } pipe_t;

endpackage

>>> hdl/qau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_front
// Product stage and sum/round stage; seeds the square-root chain.
// ----------------------------------------------------------------------------
module qau_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  qau_pkg::in_t   operand,
    output qau_pkg::pipe_t word
);

    localparam int DW  = qau_pkg::DATA_WIDTH;
    localparam int F   = qau_pkg::FRAC_BITS;
    localparam int PW  = qau_pkg::PW;
    localparam int AW  = qau_pkg::AW;
    localparam int SW  = qau_pkg::SW;
    localparam int SQW = qau_pkg::SQW;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (F - 1);
    localparam logic signed [AW-1:0] ONE  = AW'(1) <<< (2 * F);
    localparam logic signed [AW-1:0] DMAX = (AW'(1) <<< (DW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] DMIN = -DMAX - AW'(1);

    function automatic logic [DW:0] rnd_sat(input logic signed [AW-1:0] t);
        logic signed [AW-1:0] r;
        logic [DW:0]          o;
        r = (t + HALF) >>> F;
        if (r > DMAX)
        begin
            o = {1'b1, DMAX[DW-1:0]};
        end
        else if (r < DMIN)
        begin
            o = {1'b1, DMIN[DW-1:0]};
        end
        else
        begin
            o = {1'b0, r[DW-1:0]};
        end
        return o;
    endfunction

    logic signed [DW-1:0] oa [16];
    logic signed [DW-1:0] ob [16];
    logic signed [DW-1:0] comp [4];
    logic signed [PW-1:0] prod_reg [16];
    logic                 valid1_reg;
    qau_pkg::cmd_t        cmd1_reg;
    logic [3:0][DW-1:0]   abs1_reg;
    logic [3:0]           neg1_reg;

    logic signed [AW-1:0] e [16];
    logic signed [AW-1:0] t [9];
    logic [SW-1:0]        ssum;
    logic [DW:0]          rs;
    qau_pkg::pipe_t       word_next;
    qau_pkg::pipe_t       data_reg;
    logic                 valid_reg;

    always_comb
    begin
        comp[0] = operand.a_w;
        comp[1] = operand.a_x;
        comp[2] = operand.a_y;
        comp[3] = operand.a_z;
        for (int i = 0; i < 16; i++)
        begin
            oa[i] = '0;
            ob[i] = '0;
        end
        unique case (qau_pkg::cmd_t'(operand.command))
            qau_pkg::CMD_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    oa[4*i]   = operand.a_w;
                    oa[4*i+1] = operand.a_x;
                    oa[4*i+2] = operand.a_y;
                    oa[4*i+3] = operand.a_z;
                end
                ob[0]  = operand.b_w; ob[1]  = operand.b_x;
                ob[2]  = operand.b_y; ob[3]  = operand.b_z;
                ob[4]  = operand.b_x; ob[5]  = operand.b_w;
                ob[6]  = operand.b_z; ob[7]  = operand.b_y;
                ob[8]  = operand.b_y; ob[9]  = operand.b_z;
                ob[10] = operand.b_w; ob[11] = operand.b_x;
                ob[12] = operand.b_z; ob[13] = operand.b_y;
                ob[14] = operand.b_x; ob[15] = operand.b_w;
            end
            qau_pkg::CMD_NORM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    oa[i] = comp[i];
                    ob[i] = comp[i];
                end
            end
            qau_pkg::CMD_MAT:
            begin
                oa[0] = operand.a_y; ob[0] = operand.a_y;
                oa[1] = operand.a_z; ob[1] = operand.a_z;
                oa[2] = operand.a_x; ob[2] = operand.a_y;
                oa[3] = operand.a_w; ob[3] = operand.a_z;
                oa[4] = operand.a_x; ob[4] = operand.a_z;
                oa[5] = operand.a_w; ob[5] = operand.a_y;
                oa[6] = operand.a_x; ob[6] = operand.a_x;
                oa[7] = operand.a_y; ob[7] = operand.a_z;
                oa[8] = operand.a_w; ob[8] = operand.a_x;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg <= qau_pkg::cmd_t'(operand.command);
        for (int i = 0; i < 16; i++)
        begin
            prod_reg[i] <= oa[i] * ob[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            neg1_reg[i] <= comp[i][DW-1];
            abs1_reg[i] <= comp[i][DW-1] ? DW'(-comp[i]) : DW'(comp[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            e[i] = AW'(prod_reg[i]);
        end
        for (int i = 0; i < 9; i++)
        begin
            t[i] = '0;
        end
        ssum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
        word_next = '0;
        word_next.valid   = valid1_reg;
        word_next.cmd     = cmd1_reg;
        word_next.mag_abs = abs1_reg;
        word_next.neg     = neg1_reg;
        word_next.s       = SQW'(ssum);
        unique case (cmd1_reg)
            qau_pkg::CMD_MUL:
            begin
                t[0] = e[0] - e[1] - e[2] - e[3];
                t[1] = e[4] + e[5] + e[6] - e[7];
                t[2] = e[8] - e[9] + e[10] + e[11];
                t[3] = e[12] + e[13] - e[14] + e[15];
            end
            qau_pkg::CMD_MAT:
            begin
                t[0] = ONE - (e[0] <<< 1) - (e[1] <<< 1);
                t[1] = (e[2] <<< 1) - (e[3] <<< 1);
                t[2] = (e[4] <<< 1) + (e[5] <<< 1);
                t[3] = (e[2] <<< 1) + (e[3] <<< 1);
                t[4] = ONE - (e[6] <<< 1) - (e[1] <<< 1);
                t[5] = (e[7] <<< 1) - (e[8] <<< 1);
                t[6] = (e[4] <<< 1) - (e[5] <<< 1);
                t[7] = (e[7] <<< 1) + (e[8] <<< 1);
                t[8] = ONE - (e[6] <<< 1) - (e[0] <<< 1);
            end
            default:
            begin
            end
        endcase
        rs = '0;
        if (cmd1_reg == qau_pkg::CMD_MUL || cmd1_reg == qau_pkg::CMD_MAT)
        begin
            for (int i = 0; i < 9; i++)
            begin
                rs = rnd_sat(t[i]);
                word_next.res[i] = rs[DW-1:0];
                word_next.ov     = word_next.ov | rs[DW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= word_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= word_next;
    end

    always_comb
    begin
        word       = data_reg;
        word.valid = valid_reg;
    end

endmodule

>>> hdl/qau_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_sqrt_cell
// One root bit of the magnitude square root per cell.
// ----------------------------------------------------------------------------
module qau_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  qau_pkg::pipe_t word_in,
    output qau_pkg::pipe_t word_out
);

    localparam int MW  = qau_pkg::MW;
    localparam int RW  = qau_pkg::RW;
    localparam int SQW = qau_pkg::SQW;

    logic [RW-1:0]  cur;
    logic [RW:0]    trial;
    qau_pkg::pipe_t word_next;
    qau_pkg::pipe_t data_reg;
    logic           valid_reg;

    always_comb
    begin
        word_next   = word_in;
        cur         = {word_in.rem[RW-3:0], word_in.s[SQW-1 -: 2]};
        trial       = {1'b0, cur} - {{(RW-MW-1){1'b0}}, word_in.root, 2'b01};
        word_next.s = {word_in.s[SQW-3:0], 2'b00};
        if (!trial[RW])
        begin
            word_next.rem  = trial[RW-1:0];
            word_next.root = {word_in.root[MW-2:0], 1'b1};
        end
        else
        begin
            word_next.rem  = cur;
            word_next.root = {word_in.root[MW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= word_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= word_next;
    end

    always_comb
    begin
        word_out       = data_reg;
        word_out.valid = valid_reg;
    end

endmodule

>>> hdl/qau_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_div_cell
// One quotient bit of the four normalize divisions per cell.
// ----------------------------------------------------------------------------
module qau_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  qau_pkg::pipe_t word_in,
    output qau_pkg::pipe_t word_out
);

    localparam int QW  = qau_pkg::QW;
    localparam int DRW = qau_pkg::DRW;

    logic [DRW-1:0] r2 [4];
    qau_pkg::pipe_t word_next;
    qau_pkg::pipe_t data_reg;
    logic           valid_reg;

    always_comb
    begin
        word_next = word_in;
        for (int i = 0; i < 4; i++)
        begin
            r2[i] = {word_in.drem[i][DRW-2:0], word_in.nbits[i][QW-1]};
            word_next.nbits[i] = {word_in.nbits[i][QW-2:0], 1'b0};
            if (r2[i] >= {1'b0, word_in.dvsr})
            begin
                word_next.drem[i] = r2[i] - {1'b0, word_in.dvsr};
                word_next.quo[i]  = {word_in.quo[i][QW-2:0], 1'b1};
            end
            else
            begin
                word_next.drem[i] = r2[i];
                word_next.quo[i]  = {word_in.quo[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= word_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= word_next;
    end

    always_comb
    begin
        word_out       = data_reg;
        word_out.valid = valid_reg;
    end

endmodule

>>> hdl/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Q2.14 quaternion multiply, normalize and rotation-matrix unit.
//
//   channel   ports                    flow
//   command   start, busy, operand     in
//   result    done, result             out
//
// One word accepted per cycle; busy stays low.
// Every command passes the same stages: products, sums, 17 square-root
// cells, 15 divider cells and the output register.
// Reset clears the valid bits of the cell chain and the done strobe.
// The receiver cannot stall; done marks a result for one cycle.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  qau_pkg::in_t  operand,
    output logic          done,
    output qau_pkg::out_t result
);

    localparam int DW  = qau_pkg::DATA_WIDTH;
    localparam int MW  = qau_pkg::MW;
    localparam int QW  = qau_pkg::QW;
    localparam int DRW = qau_pkg::DRW;
    localparam int NW  = qau_pkg::NW;
    localparam int EW  = DW + QW + 1;
    localparam logic signed [EW-1:0] DMAX = (EW'(1) <<< (DW - 1)) - EW'(1);
    localparam logic signed [EW-1:0] DMIN = -DMAX - EW'(1);

    qau_pkg::pipe_t sq_word [MW+1];
    qau_pkg::pipe_t dv_word [QW+1];
    qau_pkg::pipe_t fw;
    logic [NW-1:0]  num [4];
    logic signed [EW-1:0] v [4];
    logic [8:0][DW-1:0] res_n;
    logic           ov_n;
    logic           zm_n;
    logic           done_reg;
    qau_pkg::out_t  result_reg;
    qau_pkg::out_t  result_next;

    assign busy = 1'b0;

    qau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .operand  (operand),
        .word     (sq_word[0])
    );

    for (genvar g = 0; g < MW; g++)
    begin : g_sqrt
        qau_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (sq_word[g]),
            .word_out (sq_word[g+1])
        );
    end

    always_comb
    begin
        dv_word[0]      = sq_word[MW];
        dv_word[0].dvsr = {sq_word[MW].root, 1'b0};
        dv_word[0].zm   = (sq_word[MW].cmd == qau_pkg::CMD_NORM) && (sq_word[MW].root == '0);
        for (int i = 0; i < 4; i++)
        begin
            num[i] = NW'({sq_word[MW].mag_abs[i], {QW{1'b0}}}) + NW'(sq_word[MW].root);
            dv_word[0].drem[i]  = DRW'(num[i][NW-1:QW]);
            dv_word[0].nbits[i] = num[i][QW-1:0];
            dv_word[0].quo[i]   = '0;
        end
    end

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        qau_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (dv_word[g]),
            .word_out (dv_word[g+1])
        );
    end

    always_comb
    begin
        fw    = dv_word[QW];
        res_n = fw.res;
        ov_n  = fw.ov;
        zm_n  = fw.zm;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = EW'(fw.quo[i]);
            if (fw.neg[i])
            begin
                v[i] = -v[i];
            end
        end
        if (fw.cmd == qau_pkg::CMD_NORM && !fw.zm)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (v[i] > DMAX)
                begin
                    res_n[i] = DMAX[DW-1:0];
                    ov_n     = 1'b1;
                end
                else if (v[i] < DMIN)
                begin
                    res_n[i] = DMIN[DW-1:0];
                    ov_n     = 1'b1;
                end
                else
                begin
                    res_n[i] = v[i][DW-1:0];
                end
            end
        end
        result_next.res_0          = res_n[0];
        result_next.res_1          = res_n[1];
        result_next.res_2          = res_n[2];
        result_next.res_3          = res_n[3];
        result_next.res_4          = res_n[4];
        result_next.res_5          = res_n[5];
        result_next.res_6          = res_n[6];
        result_next.res_7          = res_n[7];
        result_next.res_8          = res_n[8];
        result_next.overflow       = ov_n;
        result_next.zero_magnitude = zm_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hdl/qau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the quaternion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input qau_pkg::out_t result
);

    logic zm_quiet;

    // zero-magnitude word carries zero res_0 and res_3 and no overflow
    assign zm_quiet = !result.overflow && (result.res_0 == '0) && (result.res_3 == '0);

    `ASSERT_NEVER(a_busy_low, clk, rst_n, busy)
    `ASSERT_IMPLIES(a_word_out, clk, rst_n, start && !busy, ##(qau_pkg::LATENCY) done)
    `ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(start, qau_pkg::LATENCY))
    `ASSERT_IMPLIES(a_zero_mag, clk, rst_n, done && result.zero_magnitude, zm_quiet)

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

>>> tb/quaternion_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// Self-checking bench for the Q2.14 quaternion unit.
//
// Directed words cover field extremes, each command, zero magnitude and the
// unused command. Random words follow, each field unit-scale, full-range noise
// or an extreme value. A local predictor computes each result on accept;
// a checker compares every done word with the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DW = qau_pkg::DATA_WIDTH;
    localparam int F  = qau_pkg::FRAC_BITS;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    qau_pkg::in_t  operand;
    logic done;
    qau_pkg::out_t result;

    qau_pkg::out_t predicted_q[$];
    bit   failed = 1'b0;
    bit   no_gaps = 1'b0;
    int   idle_cycles = 0;
    bit   watchdog_tripped = 1'b0;

    quaternion_arithmetic_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // rounded, saturated fixed-point reduction of an exact product-scale sum
    function automatic logic signed [DW-1:0] round_sat(input longint sum, inout bit ov);
        longint v;
        begin
            v = (sum + (64'sd1 <<< (F - 1))) >>> F;
            if (v > 32767)
            begin
                ov = 1'b1;
                v  = 32767;
            end
            else if (v < -32768)
            begin
                ov = 1'b1;
                v  = -32768;
            end
            return v[DW-1:0];
        end
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint r;
        longint b;
        begin
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n)
                b = b >>> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        end
    endfunction

    function automatic qau_pkg::out_t predict_quaternion(input qau_pkg::in_t op);
        qau_pkg::out_t o;
        bit     ov;
        longint w, x, y, z, bw, bx, by, bz, one, s, mag, m, n, v;
        longint c[4];
        longint t[9];
        begin
            o  = '0;
            ov = 1'b0;
            w  = op.a_w; x  = op.a_x; y  = op.a_y; z  = op.a_z;
            bw = op.b_w; bx = op.b_x; by = op.b_y; bz = op.b_z;
            one = 64'sd1 <<< (2 * F);
            case (qau_pkg::cmd_t'(op.command))
                qau_pkg::CMD_MUL:
                begin
                    o.res_0 = round_sat(w*bw - x*bx - y*by - z*bz, ov);
                    o.res_1 = round_sat(w*bx + x*bw + y*bz - z*by, ov);
                    o.res_2 = round_sat(w*by - x*bz + y*bw + z*bx, ov);
                    o.res_3 = round_sat(w*bz + x*by - y*bx + z*bw, ov);
                end
                qau_pkg::CMD_NORM:
                begin
                    c[0] = w; c[1] = x; c[2] = y; c[3] = z;
                    s   = w*w + x*x + y*y + z*z;
                    mag = int_sqrt(s);
                    if (mag == 0)
                        o.zero_magnitude = 1'b1;
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            m = (c[i] < 0) ? -c[i] : c[i];
                            n = ((m <<< (F + 1)) + mag) / (2 * mag);
                            v = (c[i] < 0) ? -n : n;
                            if (v > 32767) begin ov = 1'b1; v = 32767; end
                            else if (v < -32768) begin ov = 1'b1; v = -32768; end
                            c[i] = v;
                        end
                        o.res_0 = c[0][15:0];
                        o.res_1 = c[1][15:0];
                        o.res_2 = c[2][15:0];
                        o.res_3 = c[3][15:0];
                    end
                end
                qau_pkg::CMD_MAT:
                begin
                    t[0] = one - 2*y*y - 2*z*z;
                    t[1] = 2*x*y - 2*w*z;
                    t[2] = 2*x*z + 2*w*y;
                    t[3] = 2*x*y + 2*w*z;
                    t[4] = one - 2*x*x - 2*z*z;
                    t[5] = 2*y*z - 2*w*x;
                    t[6] = 2*x*z - 2*w*y;
                    t[7] = 2*y*z + 2*w*x;
                    t[8] = one - 2*x*x - 2*y*y;
                    o.res_0 = round_sat(t[0], ov);
                    o.res_1 = round_sat(t[1], ov);
                    o.res_2 = round_sat(t[2], ov);
                    o.res_3 = round_sat(t[3], ov);
                    o.res_4 = round_sat(t[4], ov);
                    o.res_5 = round_sat(t[5], ov);
                    o.res_6 = round_sat(t[6], ov);
                    o.res_7 = round_sat(t[7], ov);
                    o.res_8 = round_sat(t[8], ov);
                end
                default: ;
            endcase
            o.overflow = ov;
            return o;
        end
    endfunction

    // start stays high between back-to-back words; it drops only for a gap
    task automatic send_word(input qau_pkg::in_t op);
        int gap;
        begin
            if (!no_gaps && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start   <= 1'b1;
            operand <= op;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predicted_q.push_back(predict_quaternion(op));
        end
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768) - 32'd16384);
        endcase
    endfunction

    function automatic qau_pkg::in_t rand_word(input qau_pkg::cmd_t cmd);
        qau_pkg::in_t op;
        begin
            op.command = cmd;
            op.a_w = rand_field(); op.a_x = rand_field();
            op.a_y = rand_field(); op.a_z = rand_field();
            op.b_w = rand_field(); op.b_x = rand_field();
            op.b_y = rand_field(); op.b_z = rand_field();
            return op;
        end
    endfunction

    task automatic test_directed();
        qau_pkg::in_t op;
        begin
            op = '0;
            op.command = qau_pkg::CMD_NORM;
            send_word(op);
            op.command = qau_pkg::CMD_MUL;
            send_word(op);
            op.command = qau_pkg::CMD_MAT;
            send_word(op);
            op.command = qau_pkg::CMD_NONE;
            op.a_w = 16'sh7fff; op.b_w = 16'sh7fff;
            send_word(op);
            for (int k = 0; k < 3; k++)
            begin
                op.command = qau_pkg::cmd_t'(k);
                op.a_w = 16'sh7fff; op.a_x = 16'sh7fff; op.a_y = 16'sh7fff;
                op.a_z = 16'sh7fff; op.b_w = 16'sh8000; op.b_x = 16'sh7fff;
                op.b_y = 16'sh8000; op.b_z = 16'sh7fff;
                send_word(op);
                op.a_w = 16'sh8000; op.a_x = 16'sh8000; op.a_y = 16'sh8000;
                op.a_z = 16'sh8000; op.b_w = 16'sh8000; op.b_x = 16'sh8000;
                op.b_y = 16'sh8000; op.b_z = 16'sh8000;
                send_word(op);
                op = '0;
                op.command = qau_pkg::cmd_t'(k);
                op.a_w = 16'sd16384; op.b_w = 16'sd16384;
                send_word(op);
                op.a_w = 16'sd11585; op.a_z = 16'sd11585;
                op.b_x = 16'sd16384; op.b_w = 16'sd0;
                send_word(op);
                op.a_w = 16'sd0; op.a_z = 16'sd0; op.a_y = -16'sd1;
                send_word(op);
            end
        end
    endtask

    task automatic test_random(input int count);
        begin
            for (int i = 0; i < count; i++)
                send_word(rand_word(qau_pkg::cmd_t'($urandom_range(0, 3))));
        end
    endtask

    task automatic test_back_to_back(input int count);
        begin
            no_gaps = 1'b1;
            for (int i = 0; i < count; i++)
                send_word(rand_word(qau_pkg::cmd_t'($urandom_range(0, 2))));
        end
    endtask

    always @(posedge clk)
    begin
        qau_pkg::out_t exp_w;
        if (rst_n && done)
        begin
            if (predicted_q.size() == 0)
            begin
                $error("result word with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                exp_w = predicted_q.pop_front();
                if (result.res_0 !== exp_w.res_0) begin failed = 1'b1;
                    $error("res_0 exp %0d got %0d", exp_w.res_0, result.res_0); end
                if (result.res_1 !== exp_w.res_1) begin failed = 1'b1;
                    $error("res_1 exp %0d got %0d", exp_w.res_1, result.res_1); end
                if (result.res_2 !== exp_w.res_2) begin failed = 1'b1;
                    $error("res_2 exp %0d got %0d", exp_w.res_2, result.res_2); end
                if (result.res_3 !== exp_w.res_3) begin failed = 1'b1;
                    $error("res_3 exp %0d got %0d", exp_w.res_3, result.res_3); end
                if (result.res_4 !== exp_w.res_4) begin failed = 1'b1;
                    $error("res_4 exp %0d got %0d", exp_w.res_4, result.res_4); end
                if (result.res_5 !== exp_w.res_5) begin failed = 1'b1;
                    $error("res_5 exp %0d got %0d", exp_w.res_5, result.res_5); end
                if (result.res_6 !== exp_w.res_6) begin failed = 1'b1;
                    $error("res_6 exp %0d got %0d", exp_w.res_6, result.res_6); end
                if (result.res_7 !== exp_w.res_7) begin failed = 1'b1;
                    $error("res_7 exp %0d got %0d", exp_w.res_7, result.res_7); end
                if (result.res_8 !== exp_w.res_8) begin failed = 1'b1;
                    $error("res_8 exp %0d got %0d", exp_w.res_8, result.res_8); end
                if (result.overflow !== exp_w.overflow) begin failed = 1'b1;
                    $error("overflow exp %0b got %0b", exp_w.overflow,
                           result.overflow); end
                if (result.zero_magnitude !== exp_w.zero_magnitude) begin
                    failed = 1'b1;
                    $error("zero_magnitude exp %0b got %0b",
                           exp_w.zero_magnitude, result.zero_magnitude); end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_tripped)
        begin
            watchdog_tripped <= 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_back_to_back(180);
        start <= 1'b0;
        while (predicted_q.size() != 0)
            @(posedge clk);
        repeat (qau_pkg::LATENCY + 5) @(posedge clk);
        if (!failed && predicted_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> quaternion_arithmetic_unit.f
+incdir+hdl
hdl/qau_pkg.sv
hdl/qau_front.sv
hdl/qau_sqrt_cell.sv
hdl/qau_div_cell.sv
hdl/quaternion_arithmetic_unit.sv
hdl/qau_checker.sv
tb/quaternion_arithmetic_unit_tb.sv
